[design/rv32id_pkg.sv]
// RV32I decoder package: opcode and funct7 codes, instruction ids, stage types.
// No dependencies; used by every other file of the decoder but rv32id_if.
`timescale 1ns / 1ps
`default_nettype none

package rv32id_pkg;

  typedef enum logic [6:0] {
    OPC_LOAD   = 7'h03,
    OPC_IARI   = 7'h13,
    OPC_AUIPC  = 7'h17,
    OPC_STORE  = 7'h23,
    OPC_R      = 7'h33,
    OPC_LUI    = 7'h37,
    OPC_BRANCH = 7'h63,
    OPC_JALR   = 7'h67,
    OPC_JAL    = 7'h6F
  } opcode_e;

  typedef enum logic [6:0] {
    F7_BASE = 7'h00,
    F7_ALT  = 7'h20
  } funct7_e;

  typedef enum logic [5:0] {
    ID_UNKNOWN = 6'd0,
    ID_ADD     = 6'd1,
    ID_SUB     = 6'd2,
    ID_SLL     = 6'd3,
    ID_SLT     = 6'd4,
    ID_SLTU    = 6'd5,
    ID_XOR     = 6'd6,
    ID_SRL     = 6'd7,
    ID_SRA     = 6'd8,
    ID_OR      = 6'd9,
    ID_AND     = 6'd10,
    ID_ADDI    = 6'd11,
    ID_SLLI    = 6'd12,
    ID_SLTI    = 6'd13,
    ID_SLTIU   = 6'd14,
    ID_XORI    = 6'd15,
    ID_SRLI    = 6'd16,
    ID_SRAI    = 6'd17,
    ID_ORI     = 6'd18,
    ID_ANDI    = 6'd19,
    ID_LB      = 6'd20,
    ID_LH      = 6'd21,
    ID_LW      = 6'd22,
    ID_LBU     = 6'd23,
    ID_LHU     = 6'd24,
    ID_SB      = 6'd25,
    ID_SH      = 6'd26,
    ID_SW      = 6'd27,
    ID_BEQ     = 6'd28,
    ID_BNE     = 6'd29,
    ID_BLT     = 6'd30,
    ID_BGE     = 6'd31,
    ID_BLTU    = 6'd32,
    ID_BGEU    = 6'd33,
    ID_LUI     = 6'd34,
    ID_AUIPC   = 6'd35,
    ID_JAL     = 6'd36,
    ID_JALR    = 6'd37
  } instr_id_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
  } s1_t;

  typedef struct packed {
    logic [6:0]         opcode_field;
    logic [4:0]         dest_reg;
    logic [2:0]         func3_field;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [6:0]         func7_field;
    logic signed [31:0] immediate;
    logic [5:0]         instr_id;
  } dec_res_t;

endpackage

`default_nettype wire

[design/rv32id_if.sv]
// Valid/ready channel interfaces for the RV32I decoder: instruction in, fields out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rv32id_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rv32id_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         opcode_field;
  logic [4:0]         dest_reg;
  logic [2:0]         func3_field;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic [6:0]         func7_field;
  logic signed [31:0] immediate;
  logic [5:0]         instr_id;

  modport source (output valid, output opcode_field, output dest_reg, output func3_field,
                  output src1_reg, output src2_reg, output func7_field, output immediate,
                  output instr_id, input ready);
  modport sink   (input valid, input opcode_field, input dest_reg, input func3_field,
                  input src1_reg, input src2_reg, input func7_field, input immediate,
                  input instr_id, output ready);
endinterface

`default_nettype wire

[design/rv32id_in_stage.sv]
// Input register of the RV32I decoder: captures one instruction word.
// Depends on rv32id_pkg and rv32id_in_if.
`timescale 1ns / 1ps
`default_nettype none

module rv32id_in_stage (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  rv32id_in_if.sink         instr_i,
  input  wire logic         adv_i,
  output rv32id_pkg::s1_t   s1_o
);

  logic        valid_q, valid_d;
  logic [31:0] word_q, word_d;
  logic        load;

  assign instr_i.ready = !valid_q || adv_i;
  assign load          = instr_i.valid && instr_i.ready;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (instr_i.ready) begin
      valid_d = instr_i.valid;
    end
    if (load) begin
      word_d = instr_i.instr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign s1_o.valid = valid_q;
  assign s1_o.word  = word_q;

endmodule

`default_nettype wire

[design/rv32id_decode.sv]
// Field split, immediate build and instruction classification for one RV32I word.
// Purely combinational; depends on rv32id_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rv32id_decode (
  input  wire logic [31:0]     word_i,
  output rv32id_pkg::dec_res_t res_o
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic        var_ok;
  logic        var_alt;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [31:0] imm;
  rv32id_pkg::instr_id_e id;

  assign opc     = word_i[6:0];
  assign f3      = word_i[14:12];
  assign f7      = word_i[31:25];
  assign var_alt = (f7 == rv32id_pkg::F7_ALT);
  assign var_ok  = (f7 == rv32id_pkg::F7_BASE) || var_alt;

  assign imm_i = {{20{word_i[31]}}, word_i[31:20]};
  assign imm_s = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
  assign imm_b = {{19{word_i[31]}}, word_i[31], word_i[7], word_i[30:25], word_i[11:8], 1'b0};
  assign imm_u = {word_i[31:12], 12'h000};
  assign imm_j = {{11{word_i[31]}}, word_i[31], word_i[19:12], word_i[20], word_i[30:21],
                  1'b0};

  always_comb begin
    imm = '0;
    id  = rv32id_pkg::ID_UNKNOWN;
    case (opc)
      rv32id_pkg::OPC_R: begin
        case (f3)
          3'd0: id = !var_ok ? rv32id_pkg::ID_UNKNOWN :
                     (var_alt ? rv32id_pkg::ID_SUB : rv32id_pkg::ID_ADD);
          3'd1: id = rv32id_pkg::ID_SLL;
          3'd2: id = rv32id_pkg::ID_SLT;
          3'd3: id = rv32id_pkg::ID_SLTU;
          3'd4: id = rv32id_pkg::ID_XOR;
          3'd5: id = !var_ok ? rv32id_pkg::ID_UNKNOWN :
                     (var_alt ? rv32id_pkg::ID_SRA : rv32id_pkg::ID_SRL);
          3'd6: id = rv32id_pkg::ID_OR;
          3'd7: id = rv32id_pkg::ID_AND;
          default: id = rv32id_pkg::ID_UNKNOWN;
        endcase
      end
      rv32id_pkg::OPC_IARI: begin
        imm = imm_i;
        case (f3)
          3'd0: id = rv32id_pkg::ID_ADDI;
          3'd1: id = rv32id_pkg::ID_SLLI;
          3'd2: id = rv32id_pkg::ID_SLTI;
          3'd3: id = rv32id_pkg::ID_SLTIU;
          3'd4: id = rv32id_pkg::ID_XORI;
          3'd5: id = !var_ok ? rv32id_pkg::ID_UNKNOWN :
                     (var_alt ? rv32id_pkg::ID_SRAI : rv32id_pkg::ID_SRLI);
          3'd6: id = rv32id_pkg::ID_ORI;
          3'd7: id = rv32id_pkg::ID_ANDI;
          default: id = rv32id_pkg::ID_UNKNOWN;
        endcase
      end
      rv32id_pkg::OPC_LOAD: begin
        imm = imm_i;
        case (f3)
          3'd0: id = rv32id_pkg::ID_LB;
          3'd1: id = rv32id_pkg::ID_LH;
          3'd2: id = rv32id_pkg::ID_LW;
          3'd4: id = rv32id_pkg::ID_LBU;
          3'd5: id = rv32id_pkg::ID_LHU;
          default: id = rv32id_pkg::ID_UNKNOWN;
        endcase
      end
      rv32id_pkg::OPC_STORE: begin
        imm = imm_s;
        case (f3)
          3'd0: id = rv32id_pkg::ID_SB;
          3'd1: id = rv32id_pkg::ID_SH;
          3'd2: id = rv32id_pkg::ID_SW;
          default: id = rv32id_pkg::ID_UNKNOWN;
        endcase
      end
      rv32id_pkg::OPC_BRANCH: begin
        imm = imm_b;
        case (f3)
          3'd0: id = rv32id_pkg::ID_BEQ;
          3'd1: id = rv32id_pkg::ID_BNE;
          3'd4: id = rv32id_pkg::ID_BLT;
          3'd5: id = rv32id_pkg::ID_BGE;
          3'd6: id = rv32id_pkg::ID_BLTU;
          3'd7: id = rv32id_pkg::ID_BGEU;
          default: id = rv32id_pkg::ID_UNKNOWN;
        endcase
      end
      rv32id_pkg::OPC_LUI: begin
        imm = imm_u;
        id  = rv32id_pkg::ID_LUI;
      end
      rv32id_pkg::OPC_AUIPC: begin
        imm = imm_u;
        id  = rv32id_pkg::ID_AUIPC;
      end
      rv32id_pkg::OPC_JAL: begin
        imm = imm_j;
        id  = rv32id_pkg::ID_JAL;
      end
      rv32id_pkg::OPC_JALR: begin
        imm = imm_i;
        id  = rv32id_pkg::ID_JALR;
      end
      default: begin
        imm = '0;
        id  = rv32id_pkg::ID_UNKNOWN;
      end
    endcase
  end

  assign res_o.opcode_field = opc;
  assign res_o.dest_reg     = word_i[11:7];
  assign res_o.func3_field  = f3;
  assign res_o.src1_reg     = word_i[19:15];
  assign res_o.src2_reg     = word_i[24:20];
  assign res_o.func7_field  = f7;
  assign res_o.immediate    = imm;
  assign res_o.instr_id     = id;

endmodule

`default_nettype wire

[design/rv32id_out_stage.sv]
// Result register of the RV32I decoder: holds one decoded word until taken.
// Depends on rv32id_pkg and rv32id_out_if.
`timescale 1ns / 1ps
`default_nettype none

module rv32id_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rv32id_pkg::s1_t      s1_i,
  input  wire rv32id_pkg::dec_res_t res_i,
  output logic                      adv_o,
  rv32id_out_if.source              dec_o
);

  logic                 valid_q, valid_d;
  rv32id_pkg::dec_res_t res_q, res_d;

  assign adv_o = !valid_q || dec_o.ready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (adv_o) begin
      valid_d = s1_i.valid;
      if (s1_i.valid) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign dec_o.valid        = valid_q;
  assign dec_o.opcode_field = res_q.opcode_field;
  assign dec_o.dest_reg     = res_q.dest_reg;
  assign dec_o.func3_field  = res_q.func3_field;
  assign dec_o.src1_reg     = res_q.src1_reg;
  assign dec_o.src2_reg     = res_q.src2_reg;
  assign dec_o.func7_field  = res_q.func7_field;
  assign dec_o.immediate    = res_q.immediate;
  assign dec_o.instr_id     = res_q.instr_id;

endmodule

`default_nettype wire

[design/rv32i_instruction_decoder_core.sv]
// Top level of the RV32I decoder: input register, decode logic, result register.
// Depends on rv32id_pkg, rv32id_if, rv32id_in_stage, rv32id_decode, rv32id_out_stage.
//
//   channel   dir   handshake      word
//   instr_i   in    valid/ready    instr_word
//   dec_o     out   valid/ready    opcode_field .. instr_id
//
// One word per cycle sustained while dec_o.ready stays high.
// The path is input register, decode logic, result register.
// Reset (rst_ni low, asynchronous) empties both registers.
// A stall on dec_o holds the result register; the input register still takes a
// word if it is empty, so two words are held before instr_i.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_instruction_decoder_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rv32id_in_if.sink    instr_i,
  rv32id_out_if.source dec_o
);

  rv32id_pkg::s1_t      s1;
  rv32id_pkg::dec_res_t res;
  logic                 adv;

  rv32id_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .instr_i (instr_i),
    .adv_i   (adv),
    .s1_o    (s1)
  );

  rv32id_decode u_dec (
    .word_i (s1.word),
    .res_o  (res)
  );

  rv32id_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1),
    .res_i  (res),
    .adv_o  (adv),
    .dec_o  (dec_o)
  );

  a_r_type_no_imm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.valid && dec_o.opcode_field == rv32id_pkg::OPC_R |-> dec_o.immediate == 32'sd0)
    else $error("R-type result carries a non-zero immediate");

  a_add_funct7: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.valid && dec_o.instr_id == rv32id_pkg::ID_ADD
      |-> dec_o.opcode_field == rv32id_pkg::OPC_R && dec_o.func7_field == rv32id_pkg::F7_BASE
        && dec_o.func3_field == 3'd0)
    else $error("ADD id without matching opcode, funct3 and funct7");

  a_lui_imm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.valid && dec_o.opcode_field == rv32id_pkg::OPC_LUI
      |-> dec_o.immediate[11:0] == 12'h000 && dec_o.instr_id == rv32id_pkg::ID_LUI)
    else $error("LUI result malformed");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1.valid && !adv |=> s1.valid && $stable(s1.word))
    else $error("input register lost a word during a stall");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1.valid && adv |=> dec_o.valid)
    else $error("decoded word not moved into the result register");

endmodule

`default_nettype wire

[dv/tb_rv32i_instruction_decoder_core.sv]
// Testbench for rv32i_instruction_decoder_core: directed words, then random words, each result
// checked field by field against an in-bench decoder of the word; for directed words the
// expected id and immediate come from a table. Depends on rv32id_pkg, rv32id_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder_core;

  localparam int NUM_DIRECTED  = 25;
  localparam int NUM_WORDS     = 650;
  localparam int LONG_HOLD_AT  = 120;
  localparam int LONG_HOLD_LEN = 80;
  localparam int DRAIN_AT      = 300;
  localparam int CALM_FROM     = 550;
  localparam int TAIL_CYCLES   = 8;

  localparam logic [2:0] F3_ADD_SUB     = 3'd0;
  localparam logic [2:0] F3_SHIFT_RIGHT = 3'd5;

  typedef struct {
    logic [31:0]          word;
    rv32id_pkg::dec_res_t fields;
  } decode_t;

  typedef struct {
    logic [31:0]           word;
    bit                    fixed;
    rv32id_pkg::instr_id_e id;
    logic [31:0]           imm;
  } vector_t;

  logic clk_i;
  logic rst_ni;

  rv32id_in_if  instr_if ();
  rv32id_out_if dec_if ();

  rv32i_instruction_decoder_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .instr_i(instr_if),
    .dec_o  (dec_if)
  );

  decode_t pending_decodes [$];
  int      error_count = 0;
  int      words_in = 0;
  bit      calm = 1'b0;

  rv32id_pkg::instr_id_e r_ids [0:7] = '{
    rv32id_pkg::ID_ADD, rv32id_pkg::ID_SLL, rv32id_pkg::ID_SLT, rv32id_pkg::ID_SLTU,
    rv32id_pkg::ID_XOR, rv32id_pkg::ID_SRL, rv32id_pkg::ID_OR, rv32id_pkg::ID_AND};
  rv32id_pkg::instr_id_e iari_ids [0:7] = '{
    rv32id_pkg::ID_ADDI, rv32id_pkg::ID_SLLI, rv32id_pkg::ID_SLTI, rv32id_pkg::ID_SLTIU,
    rv32id_pkg::ID_XORI, rv32id_pkg::ID_SRLI, rv32id_pkg::ID_ORI, rv32id_pkg::ID_ANDI};
  rv32id_pkg::instr_id_e load_ids [0:7] = '{
    rv32id_pkg::ID_LB, rv32id_pkg::ID_LH, rv32id_pkg::ID_LW, rv32id_pkg::ID_UNKNOWN,
    rv32id_pkg::ID_LBU, rv32id_pkg::ID_LHU, rv32id_pkg::ID_UNKNOWN, rv32id_pkg::ID_UNKNOWN};
  rv32id_pkg::instr_id_e store_ids [0:7] = '{
    rv32id_pkg::ID_SB, rv32id_pkg::ID_SH, rv32id_pkg::ID_SW, rv32id_pkg::ID_UNKNOWN,
    rv32id_pkg::ID_UNKNOWN, rv32id_pkg::ID_UNKNOWN, rv32id_pkg::ID_UNKNOWN,
    rv32id_pkg::ID_UNKNOWN};
  rv32id_pkg::instr_id_e branch_ids [0:7] = '{
    rv32id_pkg::ID_BEQ, rv32id_pkg::ID_BNE, rv32id_pkg::ID_UNKNOWN, rv32id_pkg::ID_UNKNOWN,
    rv32id_pkg::ID_BLT, rv32id_pkg::ID_BGE, rv32id_pkg::ID_BLTU, rv32id_pkg::ID_BGEU};

  rv32id_pkg::opcode_e known_opcodes [0:8] = '{
    rv32id_pkg::OPC_LOAD, rv32id_pkg::OPC_IARI, rv32id_pkg::OPC_AUIPC,
    rv32id_pkg::OPC_STORE, rv32id_pkg::OPC_R, rv32id_pkg::OPC_LUI,
    rv32id_pkg::OPC_BRANCH, rv32id_pkg::OPC_JALR, rv32id_pkg::OPC_JAL};

  vector_t directed [0:NUM_DIRECTED-1] = '{
    '{32'h0000_0000, 1'b1, rv32id_pkg::ID_UNKNOWN, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b1, rv32id_pkg::ID_UNKNOWN, 32'h0000_0000},
    '{32'h0031_00B3, 1'b1, rv32id_pkg::ID_ADD,     32'h0000_0000},
    '{32'h4031_00B3, 1'b1, rv32id_pkg::ID_SUB,     32'h0000_0000},
    '{32'h0231_00B3, 1'b1, rv32id_pkg::ID_UNKNOWN, 32'h0000_0000},
    '{32'h4031_50B3, 1'b1, rv32id_pkg::ID_SRA,     32'h0000_0000},
    '{32'hFE31_50B3, 1'b1, rv32id_pkg::ID_UNKNOWN, 32'h0000_0000},
    '{32'hFE31_10B3, 1'b1, rv32id_pkg::ID_SLL,     32'h0000_0000},
    '{32'h7FF0_0093, 1'b1, rv32id_pkg::ID_ADDI,    32'h0000_07FF},
    '{32'hFFF0_0093, 1'b1, rv32id_pkg::ID_ADDI,    32'hFFFF_FFFF},
    '{32'h41F0_D093, 1'b1, rv32id_pkg::ID_SRAI,    32'h0000_041F},
    '{32'h0200_D093, 1'b1, rv32id_pkg::ID_UNKNOWN, 32'h0000_0020},
    '{32'hFE00_1093, 1'b1, rv32id_pkg::ID_SLLI,    32'hFFFF_FFE0},
    '{32'h0000_3083, 1'b1, rv32id_pkg::ID_UNKNOWN, 32'h0000_0000},
    '{32'h8000_2083, 1'b1, rv32id_pkg::ID_LW,      32'hFFFF_F800},
    '{32'h0000_3023, 1'b1, rv32id_pkg::ID_UNKNOWN, 32'h0000_0000},
    '{32'h8000_2023, 1'b1, rv32id_pkg::ID_SW,      32'hFFFF_F800},
    '{32'hFE00_0FE3, 1'b1, rv32id_pkg::ID_BEQ,     32'hFFFF_FFFE},
    '{32'h0000_2063, 1'b1, rv32id_pkg::ID_UNKNOWN, 32'h0000_0000},
    '{32'hFFFF_F0B7, 1'b1, rv32id_pkg::ID_LUI,     32'hFFFF_F000},
    '{32'h0000_1017, 1'b1, rv32id_pkg::ID_AUIPC,   32'h0000_1000},
    '{32'h8000_00EF, 1'b1, rv32id_pkg::ID_JAL,     32'hFFF0_0000},
    '{32'h7FFF_F0EF, 1'b1, rv32id_pkg::ID_JAL,     32'h000F_FFFE},
    '{32'h0000_70E7, 1'b1, rv32id_pkg::ID_JALR,    32'h0000_0000},
    '{32'h0000_000F, 1'b1, rv32id_pkg::ID_UNKNOWN, 32'h0000_0000}
  };

  function automatic rv32id_pkg::instr_id_e pick_variant(rv32id_pkg::instr_id_e base_id,
                                                         rv32id_pkg::instr_id_e alt_id,
                                                         logic [6:0] f7);
    if (f7 == rv32id_pkg::F7_BASE) return base_id;
    if (f7 == rv32id_pkg::F7_ALT) return alt_id;
    return rv32id_pkg::ID_UNKNOWN;
  endfunction

  function automatic rv32id_pkg::dec_res_t decode_word(logic [31:0] w);
    rv32id_pkg::dec_res_t r;
    logic [2:0]           f3;
    logic [6:0]           f7;
    f3 = w[14:12];
    f7 = w[31:25];
    r.opcode_field = w[6:0];
    r.dest_reg     = w[11:7];
    r.func3_field  = f3;
    r.src1_reg     = w[19:15];
    r.src2_reg     = w[24:20];
    r.func7_field  = f7;
    r.immediate    = '0;
    r.instr_id     = rv32id_pkg::ID_UNKNOWN;
    case (rv32id_pkg::opcode_e'(w[6:0]))
      rv32id_pkg::OPC_R: begin
        r.instr_id = r_ids[f3];
        if (f3 == F3_ADD_SUB)
          r.instr_id = pick_variant(rv32id_pkg::ID_ADD, rv32id_pkg::ID_SUB, f7);
        if (f3 == F3_SHIFT_RIGHT)
          r.instr_id = pick_variant(rv32id_pkg::ID_SRL, rv32id_pkg::ID_SRA, f7);
      end
      rv32id_pkg::OPC_IARI: begin
        r.immediate = {{20{w[31]}}, w[31:20]};
        r.instr_id  = iari_ids[f3];
        if (f3 == F3_SHIFT_RIGHT)
          r.instr_id = pick_variant(rv32id_pkg::ID_SRLI, rv32id_pkg::ID_SRAI, f7);
      end
      rv32id_pkg::OPC_LOAD: begin
        r.immediate = {{20{w[31]}}, w[31:20]};
        r.instr_id  = load_ids[f3];
      end
      rv32id_pkg::OPC_STORE: begin
        r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        r.instr_id  = store_ids[f3];
      end
      rv32id_pkg::OPC_BRANCH: begin
        r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        r.instr_id  = branch_ids[f3];
      end
      rv32id_pkg::OPC_LUI: begin
        r.immediate = {w[31:12], 12'h000};
        r.instr_id  = rv32id_pkg::ID_LUI;
      end
      rv32id_pkg::OPC_AUIPC: begin
        r.immediate = {w[31:12], 12'h000};
        r.instr_id  = rv32id_pkg::ID_AUIPC;
      end
      rv32id_pkg::OPC_JAL: begin
        r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r.instr_id  = rv32id_pkg::ID_JAL;
      end
      rv32id_pkg::OPC_JALR: begin
        r.immediate = {{20{w[31]}}, w[31:20]};
        r.instr_id  = rv32id_pkg::ID_JALR;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] word, logic [31:0] got,
                                 logic [31:0] want);
    $display("%0t MISMATCH %s word=%h got=%h want=%h", $realtime, what, word, got, want);
    error_count++;
  endtask

  task automatic send_word(decode_t e);
    @(negedge clk_i);
    instr_if.valid      <= 1'b1;
    instr_if.instr_word <= e.word;
    do @(posedge clk_i); while (!instr_if.ready);
    pending_decodes.push_back(e);
    words_in++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random stalls, one long hold to back up the pipeline
  initial begin
    bit held_long;
    int stall;
    held_long = 1'b0;
    dec_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = 0;
      if (!held_long && words_in >= LONG_HOLD_AT) begin
        held_long = 1'b1;
        stall = LONG_HOLD_LEN;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 18);
      end
      if (stall > 0) begin
        dec_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      dec_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    decode_t              want;
    rv32id_pkg::dec_res_t got;
    if (rst_ni && dec_if.valid && dec_if.ready) begin
      got.opcode_field = dec_if.opcode_field;
      got.dest_reg     = dec_if.dest_reg;
      got.func3_field  = dec_if.func3_field;
      got.src1_reg     = dec_if.src1_reg;
      got.src2_reg     = dec_if.src2_reg;
      got.func7_field  = dec_if.func7_field;
      got.immediate    = dec_if.immediate;
      got.instr_id     = dec_if.instr_id;
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, {26'h0, got.instr_id}, 32'h0);
      end else begin
        want = pending_decodes.pop_front();
        if (got.opcode_field !== want.fields.opcode_field)
          report_mismatch("opcode_field", want.word, 32'(got.opcode_field),
                          32'(want.fields.opcode_field));
        if (got.dest_reg !== want.fields.dest_reg)
          report_mismatch("dest_reg", want.word, 32'(got.dest_reg),
                          32'(want.fields.dest_reg));
        if (got.func3_field !== want.fields.func3_field)
          report_mismatch("func3_field", want.word, 32'(got.func3_field),
                          32'(want.fields.func3_field));
        if (got.src1_reg !== want.fields.src1_reg)
          report_mismatch("src1_reg", want.word, 32'(got.src1_reg),
                          32'(want.fields.src1_reg));
        if (got.src2_reg !== want.fields.src2_reg)
          report_mismatch("src2_reg", want.word, 32'(got.src2_reg),
                          32'(want.fields.src2_reg));
        if (got.func7_field !== want.fields.func7_field)
          report_mismatch("func7_field", want.word, 32'(got.func7_field),
                          32'(want.fields.func7_field));
        if (got.immediate !== want.fields.immediate)
          report_mismatch("immediate", want.word, got.immediate, want.fields.immediate);
        if (got.instr_id !== want.fields.instr_id)
          report_mismatch("instr_id", want.word, 32'(got.instr_id),
                          32'(want.fields.instr_id));
      end
    end
  end

  initial begin
    decode_t     e;
    logic [31:0] w;
    int          gap;
    rst_ni = 1'b0;
    instr_if.valid = 1'b0;
    instr_if.instr_word = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_WORDS; i++) begin
      if (i < NUM_DIRECTED) begin
        w = directed[i].word;
      end else if ($urandom_range(0, 4) == 0) begin
        w = $urandom;
      end else begin
        w = $urandom;
        w[6:0] = known_opcodes[$urandom_range(0, 8)];
        case ($urandom_range(0, 3))
          0, 1: w[31:25] = rv32id_pkg::F7_BASE;
          2: w[31:25] = rv32id_pkg::F7_ALT;
          default: begin
          end
        endcase
      end
      e.word = w;
      e.fields = decode_word(w);
      if (i < NUM_DIRECTED && directed[i].fixed) begin
        e.fields.instr_id  = directed[i].id;
        e.fields.immediate = directed[i].imm;
      end
      calm = (i >= CALM_FROM);
      send_word(e);

      gap = 0;
      if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
      if (i == DRAIN_AT) begin
        @(negedge clk_i);
        instr_if.valid <= 1'b0;
        while (pending_decodes.size() != 0) @(negedge clk_i);
      end else if (gap > 0) begin
        @(negedge clk_i);
        instr_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    instr_if.valid <= 1'b0;

    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
design/rv32id_pkg.sv
design/rv32id_if.sv
design/rv32id_in_stage.sv
design/rv32id_decode.sv
design/rv32id_out_stage.sv
design/rv32i_instruction_decoder_core.sv
dv/tb_rv32i_instruction_decoder_core.sv
